// ===== rtl/core/contiguous_page_run_allocator_assert.svh =====
// Assertion helpers used by the allocator RTL.
`ifndef CONTIGUOUS_PAGE_RUN_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_PAGE_RUN_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define CPRA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, held off during reset.
`define CPRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== rtl/core/cpra_pkg.sv =====
package cpra_pkg;

  localparam int NUM_PAGES = 256;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int EXTRA_W   = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 9;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_SHRINK = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_RUN  = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;
  localparam logic [1:0] ST_BAD_OFF = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PAGES = 1'd1;

  typedef struct packed {
    logic               we;
    logic [PAGE_W-1:0]  addr;
    logic [EXTRA_W-1:0] data;
  } cpra_wr_t;

endpackage

// ===== rtl/core/cpra_extra_mem.sv =====
module cpra_extra_mem (
  input  logic                          clk,
  input  logic                          rst,
  input  cpra_pkg::cpra_wr_t            wr,
  input  logic [cpra_pkg::PAGE_W-1:0]   rd_addr,
  output logic [cpra_pkg::EXTRA_W-1:0]  rd_data
);

  logic [cpra_pkg::EXTRA_W-1:0] mem [cpra_pkg::NUM_PAGES];
  logic [cpra_pkg::NUM_PAGES-1:0] valid;
  logic [cpra_pkg::EXTRA_W-1:0] q;
  logic                         qv;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    q <= mem[rd_addr];
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      qv    <= 1'b0;
    end else begin
      if (wr.we) begin
        valid[wr.addr] <= 1'b1;
      end
      qv <= valid[rd_addr];
    end
  end

  assign rd_data = qv ? q : '0;

endmodule

// ===== rtl/core/contiguous_page_run_allocator.sv =====
// Each request passes through decode and check states; done pulses the cycle after the last step.
// Allocate: a first-fit walk scans the pages, then marks the pages of the run (one page a cycle).
// Free and shrink: walk the pages of the release range; errors and an uncut shrink end at the check.
// A new request is taken in the cycle that done is high; one request at a time.
// Synchronous reset: all pages free, run counts zero, page_shift 12, active_pages 256.
// Results are strobed on done for one cycle and cannot be stalled.
`include "contiguous_page_run_allocator_assert.svh"

module contiguous_page_run_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cpra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpra_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      command,
  input  logic [23:0]                     byte_length,
  input  logic [23:0]                     byte_offset,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [7:0]                      start_page,
  output logic [8:0]                      pages_changed
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_CHECK   = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_MARK    = 3'd4;
  localparam logic [2:0] S_RELEASE = 3'd5;

  logic [2:0]  state;
  logic [4:0]  page_shift;
  logic [8:0]  active_pages;
  logic [cpra_pkg::NUM_PAGES-1:0] page_used;

  logic [1:0]  cmd_q;
  logic [23:0] len_q;
  logic [23:0] off_q;
  logic [20:0] np_q;
  logic [19:0] first_q;
  logic [9:0]  p;
  logic [7:0]  rs;
  logic [8:0]  rl;
  logic [7:0]  last_q;
  logic [8:0]  hi;
  logic [8:0]  cnt_n;

  logic [4:0]  sh_eff;
  logic [8:0]  act_eff;
  logic [24:0] mask_w;
  logic [24:0] sum_w;
  logic [20:0] np_calc;
  logic [19:0] first_calc;
  logic [7:0]  extra_rd;
  logic [9:0]  end_w;
  logic        off_bad;
  logic        len_zero;
  logic        shrink_cut;
  logic        cur_used;
  cpra_pkg::cpra_wr_t wr;

  always_comb begin
    if (page_shift < 5'd4) begin
      sh_eff = 5'd4;
    end else if (page_shift > 5'd16) begin
      sh_eff = 5'd16;
    end else begin
      sh_eff = page_shift;
    end
    if (active_pages == 9'd0) begin
      act_eff = 9'd1;
    end else if (active_pages > 9'd256) begin
      act_eff = 9'd256;
    end else begin
      act_eff = active_pages;
    end
  end

  // Round length up to whole pages; truncate offset to its page.
  assign mask_w     = (25'd1 << sh_eff) - 25'd1;
  assign sum_w      = {1'b0, len_q} + mask_w;
  assign np_calc    = 21'(sum_w >> sh_eff);
  assign first_calc = 20'(off_q >> sh_eff);

  assign off_bad    = first_q >= {11'd0, act_eff};
  assign len_zero   = len_q == 24'd0;
  assign shrink_cut = np_q <= {13'd0, extra_rd};
  assign end_w      = {2'd0, first_q[7:0]} + {2'd0, extra_rd} + 10'd1;
  assign cur_used   = page_used[p[7:0]];

  always_comb begin
    wr = '0;
    if (state == S_MARK) begin
      wr.we   = 1'b1;
      wr.addr = p[7:0];
      wr.data = (p[7:0] == rs) ? (np_q[7:0] - 8'd1) : 8'd0;
    end else if (state == S_CHECK && cmd_q == cpra_pkg::CMD_SHRINK && !off_bad &&
                 !len_zero && shrink_cut) begin
      wr.we   = 1'b1;
      wr.addr = first_q[7:0];
      wr.data = np_q[7:0] - 8'd1;
    end
  end

  cpra_extra_mem u_extra (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (first_calc[7:0]),
    .rd_data (extra_rd)
  );

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift   <= 5'd12;
      active_pages <= 9'd256;
    end else if (cfg_we) begin
      if (cfg_index == cpra_pkg::CFG_PAGE_SHIFT) begin
        page_shift <= cfg_data[4:0];
      end else begin
        active_pages <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      page_used     <= '0;
      done          <= 1'b0;
      status        <= cpra_pkg::ST_OK;
      start_page    <= 8'd0;
      pages_changed <= 9'd0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= command;
            len_q <= byte_length;
            off_q <= byte_offset;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          np_q    <= np_calc;
          first_q <= first_calc;
          state   <= S_CHECK;
        end
        S_CHECK: begin
          hi <= (end_w > {1'b0, act_eff}) ? act_eff : end_w[8:0];
          priority if (cmd_q == cpra_pkg::CMD_ALLOC) begin
            if (len_zero || np_q > {12'd0, act_eff}) begin
              done          <= 1'b1;
              status        <= cpra_pkg::ST_BAD_LEN;
              start_page    <= 8'd0;
              pages_changed <= 9'd0;
              state         <= S_IDLE;
            end else begin
              p     <= 10'd0;
              rs    <= 8'd0;
              rl    <= 9'd0;
              state <= S_SCAN;
            end
          end else if (cmd_q == cpra_pkg::CMD_FREE || cmd_q == cpra_pkg::CMD_SHRINK) begin
            cnt_n <= 9'd0;
            if (off_bad) begin
              done          <= 1'b1;
              status        <= cpra_pkg::ST_BAD_OFF;
              start_page    <= 8'd0;
              pages_changed <= 9'd0;
              state         <= S_IDLE;
            end else if (cmd_q == cpra_pkg::CMD_FREE) begin
              p     <= {2'd0, first_q[7:0]};
              state <= S_RELEASE;
            end else if (len_zero) begin
              done          <= 1'b1;
              status        <= cpra_pkg::ST_BAD_LEN;
              start_page    <= 8'd0;
              pages_changed <= 9'd0;
              state         <= S_IDLE;
            end else if (shrink_cut) begin
              // Keep np pages, release the tail after them.
              p     <= {2'd0, first_q[7:0]} + {2'd0, np_q[7:0]};
              state <= S_RELEASE;
            end else begin
              done          <= 1'b1;
              status        <= cpra_pkg::ST_OK;
              start_page    <= first_q[7:0];
              pages_changed <= 9'd0;
              state         <= S_IDLE;
            end
          end else begin
            done          <= 1'b1;
            status        <= cpra_pkg::ST_BAD_LEN;
            start_page    <= 8'd0;
            pages_changed <= 9'd0;
            state         <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (p >= {1'b0, act_eff}) begin
            done          <= 1'b1;
            status        <= cpra_pkg::ST_NO_RUN;
            start_page    <= 8'd0;
            pages_changed <= 9'd0;
            state         <= S_IDLE;
          end else if (cur_used) begin
            // Restart the candidate run after a used page.
            rs <= p[7:0] + 8'd1;
            rl <= 9'd0;
            p  <= p + 10'd1;
          end else if ({12'd0, rl + 9'd1} == np_q) begin
            last_q <= p[7:0];
            p      <= {2'd0, rs};
            state  <= S_MARK;
          end else begin
            rl <= rl + 9'd1;
            p  <= p + 10'd1;
          end
        end
        S_MARK: begin
          page_used[p[7:0]] <= 1'b1;
          if (p[7:0] == last_q) begin
            done          <= 1'b1;
            status        <= cpra_pkg::ST_OK;
            start_page    <= rs;
            pages_changed <= np_q[8:0];
            state         <= S_IDLE;
          end else begin
            p <= p + 10'd1;
          end
        end
        S_RELEASE: begin
          if (p >= {1'b0, hi}) begin
            done          <= 1'b1;
            status        <= cpra_pkg::ST_OK;
            start_page    <= first_q[7:0];
            pages_changed <= cnt_n;
            state         <= S_IDLE;
          end else begin
            if (cur_used) begin
              cnt_n <= cnt_n + 9'd1;
            end
            page_used[p[7:0]] <= 1'b0;
            p <= p + 10'd1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CPRA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `CPRA_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  `CPRA_ASSERT_IMPL(a_err_zero, clk, rst, done && (status != cpra_pkg::ST_OK), (start_page == 8'd0) && (pages_changed == 9'd0))
  `CPRA_ASSERT_IMPL(a_mark_free, clk, rst, state == S_MARK, !cur_used)

endmodule
